// ===== hw/rtl/urfr_pkg.sv =====
// ----------------------------------------------------------------------------
// urfr_pkg: shared types, constants and decode functions
// Command format between the front and back halves of the reply rewriter,
// header byte remapping, checksum terms and the reply text table.
// ----------------------------------------------------------------------------
package urfr_pkg;

  // Frame position range
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);

  // Held-back header: Ethernet + IPv4 + UDP ports
  localparam int HDR_BYTES = 38;
  localparam int IDX_W     = $clog2(HDR_BYTES);

  // Header store holds two banks so that one frame can fill while the other drains
  localparam int RAM_DEPTH = 2 * HDR_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // Checksum accumulator: eight header words plus the length word, no overflow
  localparam int ACC_W = 20;

  // Command queue and output buffer depths
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int OB_DEPTH   = 4;
  localparam int OB_AW      = $clog2(OB_DEPTH);

  // Rewritten field values
  localparam logic [7:0] IP_TOTAL_LEN_LO = 8'h2C;
  localparam logic [7:0] UDP_LEN_LO      = 8'h18;
  localparam int         UDP_LEN_POS     = 38;
  localparam int         TEXT_OFF        = 42;
  localparam int         TEXT_LEN        = 16;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_FLUSH,
    CMD_BURST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             bank;
    logic [IDX_W-1:0] last_idx;
    logic [15:0]      cks;
    logic [7:0]       data;
    logic             last;
  } cmd_t;

  typedef enum logic [2:0] {
    SRC_RAM,
    SRC_ZERO,
    SRC_LEN,
    SRC_CKS_HI,
    SRC_CKS_LO
  } src_kind_t;

  typedef struct packed {
    src_kind_t        kind;
    logic [IDX_W-1:0] idx;
  } burst_src_t;

  // Bank release from the back half once a header read-out has been issued
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // Map output position to source: swap MACs, IPs, ports; set length and checksum
  function automatic burst_src_t burst_map(input logic [IDX_W-1:0] i);
    burst_src_t m;
    m.kind = SRC_RAM;
    m.idx  = i;
    if (i < 6) begin
      m.idx = i + IDX_W'(6);
    end else if (i < 12) begin
      m.idx = i - IDX_W'(6);
    end else if (i == 16) begin
      m.kind = SRC_ZERO;
    end else if (i == 17) begin
      m.kind = SRC_LEN;
    end else if (i == 24) begin
      m.kind = SRC_CKS_HI;
    end else if (i == 25) begin
      m.kind = SRC_CKS_LO;
    end else if (i >= 26 && i < 30) begin
      m.idx = i + IDX_W'(4);
    end else if (i >= 30 && i < 34) begin
      m.idx = i - IDX_W'(4);
    end else if (i == 34 || i == 35) begin
      m.idx = i + IDX_W'(2);
    end else if (i == 36 || i == 37) begin
      m.idx = i - IDX_W'(2);
    end
    return m;
  endfunction

  // Checksum contribution of one received header byte; address swaps do not
  // change the sum, and the fixed length word is preloaded
  function automatic logic [ACC_W-1:0] cks_term(input logic [IDX_W-1:0] i,
                                                input logic [7:0] b);
    logic used;
    used = (i >= 14 && i < 16) || (i >= 18 && i < 24) || (i >= 26 && i < 34);
    if (!used) begin
      return '0;
    end else if (i[0]) begin
      return ACC_W'(b);
    end else begin
      return ACC_W'({b, 8'h00});
    end
  endfunction

  // Reply text "Processado (cru)"
  function automatic logic [7:0] reply_text(input logic [3:0] k);
    logic [7:0] c;
    unique case (k)
      4'd0:  c = 8'h50;
      4'd1:  c = 8'h72;
      4'd2:  c = 8'h6F;
      4'd3:  c = 8'h63;
      4'd4:  c = 8'h65;
      4'd5:  c = 8'h73;
      4'd6:  c = 8'h73;
      4'd7:  c = 8'h61;
      4'd8:  c = 8'h64;
      4'd9:  c = 8'h6F;
      4'd10: c = 8'h20;
      4'd11: c = 8'h28;
      4'd12: c = 8'h63;
      4'd13: c = 8'h72;
      4'd14: c = 8'h75;
      4'd15: c = 8'h29;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Rewrite a byte past the header: UDP length, zero checksum, reply text
  function automatic logic [7:0] payload_byte(input logic [POS_W-1:0] pos,
                                              input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (pos == UDP_LEN_POS) begin
      v = 8'h00;
    end else if (pos == UDP_LEN_POS + 1) begin
      v = UDP_LEN_LO;
    end else if (pos == UDP_LEN_POS + 2 || pos == UDP_LEN_POS + 3) begin
      v = 8'h00;
    end else if (pos >= TEXT_OFF && pos < TEXT_OFF + TEXT_LEN) begin
      v = reply_text(4'(pos - POS_W'(TEXT_OFF)));
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/urfr_ram.sv =====
// ----------------------------------------------------------------------------
// urfr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module urfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 76
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/urfr_front.sv =====
// ----------------------------------------------------------------------------
// urfr_front: intake and classification
// Tracks the frame position, stores header bytes into the free bank, keeps a
// running header checksum and issues commands for the back half.
// ----------------------------------------------------------------------------
module urfr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        full,
  input  logic                        q_full,
  output logic                        cmd_push,
  output urfr_pkg::cmd_t              cmd,
  output logic                        ram_we,
  output logic [urfr_pkg::RAM_AW-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata,
  input  urfr_pkg::release_t          rel
);

  logic [urfr_pkg::POS_W-1:0] pos;
  logic                       bank;
  logic [1:0]                 pending;
  logic [1:0]                 pending_next;
  logic [urfr_pkg::ACC_W-1:0] acc;
  logic                       accept;
  logic                       in_hdr;
  logic [urfr_pkg::IDX_W-1:0] hdr_idx;
  logic                       need_cmd;
  logic [16:0]                fold1;
  logic [15:0]                fold2;

  assign in_hdr  = pos < urfr_pkg::POS_W'(urfr_pkg::HDR_BYTES);
  assign hdr_idx = pos[urfr_pkg::IDX_W-1:0];

  // Hold off while the command queue is full or the target bank still waits to be read out
  assign full   = q_full || (in_hdr && pending[bank]);
  assign accept = push && !full;

  // Header store write
  assign ram_we    = accept && in_hdr;
  assign ram_wdata = data_byte;
  assign ram_waddr = bank ? urfr_pkg::RAM_AW'(hdr_idx) + urfr_pkg::RAM_AW'(urfr_pkg::HDR_BYTES)
                          : urfr_pkg::RAM_AW'(hdr_idx);

  // Fold the accumulated sum and invert
  assign fold1 = 17'(acc[15:0]) + 17'(acc[urfr_pkg::ACC_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  // Classify the request
  always_comb begin
    need_cmd     = 1'b0;
    cmd.kind     = urfr_pkg::CMD_BYTE;
    cmd.bank     = bank;
    cmd.last_idx = hdr_idx;
    cmd.cks      = ~fold2;
    cmd.data     = urfr_pkg::payload_byte(pos, data_byte);
    cmd.last     = last_byte;
    if (in_hdr) begin
      if (hdr_idx == urfr_pkg::IDX_W'(urfr_pkg::HDR_BYTES - 1)) begin
        need_cmd = 1'b1;
        cmd.kind = urfr_pkg::CMD_BURST;
      end else if (last_byte) begin
        need_cmd = 1'b1;
        cmd.kind = urfr_pkg::CMD_FLUSH;
      end
    end else begin
      need_cmd = 1'b1;
    end
  end

  assign cmd_push = accept && need_cmd;

  // Mark banks busy until their read-out has been issued
  always_comb begin
    pending_next = pending;
    if (rel.valid) begin
      pending_next[rel.bank] = 1'b0;
    end
    if (cmd_push && cmd.kind != urfr_pkg::CMD_BYTE) begin
      pending_next[bank] = 1'b1;
    end
  end

  // Advance position, bank and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      bank    <= 1'b0;
      pending <= '0;
      acc     <= '0;
    end else begin
      pending <= pending_next;
      if (accept) begin
        if (in_hdr) begin
          if (pos == '0) begin
            acc <= urfr_pkg::ACC_W'(urfr_pkg::IP_TOTAL_LEN_LO);
          end else begin
            acc <= acc + urfr_pkg::cks_term(hdr_idx, data_byte);
          end
        end
        if (last_byte) begin
          pos  <= '0;
          bank <= ~bank;
        end else if (pos < urfr_pkg::POS_W'(urfr_pkg::MAX_FRAME_BYTES - 1)) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/urfr_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// urfr_cmd_queue: command queue between front and back
// Small register FIFO so that intake and read-out stall independently.
// ----------------------------------------------------------------------------
module urfr_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  urfr_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output urfr_pkg::cmd_t rd_cmd,
  output logic           empty
);

  urfr_pkg::cmd_t               entries [urfr_pkg::CMDQ_DEPTH];
  logic [urfr_pkg::CMDQ_AW-1:0] wp;
  logic [urfr_pkg::CMDQ_AW-1:0] rp;
  logic [urfr_pkg::CMDQ_AW:0]   count;

  assign full   = count == (urfr_pkg::CMDQ_AW + 1)'(urfr_pkg::CMDQ_DEPTH);
  assign empty  = count == '0;
  assign rd_cmd = entries[rp];

  // Store commands
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wp] <= wr_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wp <= wp + 1'b1;
      end
      if (rd_en) begin
        rp <= rp + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/urfr_back.sv =====
// ----------------------------------------------------------------------------
// urfr_back: command execution and output buffer
// Expands each command into result bytes, reading the header store one byte
// a cycle while the output buffer has room, and queues the results for the receiver.
// ----------------------------------------------------------------------------
module urfr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  urfr_pkg::cmd_t              head,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic [urfr_pkg::RAM_AW-1:0] ram_raddr,
  input  logic [7:0]                  ram_rdata,
  output urfr_pkg::release_t          rel,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic                        empty,
  input  logic                        pop
);

  urfr_pkg::cmd_t             cur;
  logic                       cur_valid;
  logic [urfr_pkg::IDX_W-1:0] idx;
  logic                       s1_valid;
  logic                       s1_ram;
  logic [7:0]                 s1_byte;
  logic                       s1_last;
  logic [7:0]                 ob_byte [urfr_pkg::OB_DEPTH];
  logic                       ob_last [urfr_pkg::OB_DEPTH];
  logic [urfr_pkg::OB_AW-1:0] ob_wp;
  logic [urfr_pkg::OB_AW-1:0] ob_rp;
  logic [urfr_pkg::OB_AW:0]   ob_count;
  logic                       space;
  logic                       issue;
  logic                       load;
  logic                       ob_rd;
  logic                       e_ram;
  logic [urfr_pkg::IDX_W-1:0] e_src;
  logic [7:0]                 e_byte;
  logic                       e_last;
  logic                       e_final;
  urfr_pkg::burst_src_t       bmap;

  // Issue only when the output buffer has room for everything in flight
  assign space = (int'(ob_count) + int'(s1_valid)) < urfr_pkg::OB_DEPTH;
  assign issue = cur_valid && space;

  // Decode the current element of the command
  always_comb begin
    bmap    = urfr_pkg::burst_map(idx);
    e_ram   = 1'b0;
    e_src   = idx;
    e_byte  = cur.data;
    e_last  = cur.last;
    e_final = 1'b1;
    unique case (cur.kind)
      urfr_pkg::CMD_BYTE: begin
        e_ram = 1'b0;
      end
      urfr_pkg::CMD_FLUSH: begin
        e_ram   = 1'b1;
        e_final = idx == cur.last_idx;
        e_last  = e_final;
      end
      urfr_pkg::CMD_BURST: begin
        e_src   = bmap.idx;
        e_final = idx == urfr_pkg::IDX_W'(urfr_pkg::HDR_BYTES - 1);
        e_last  = cur.last && e_final;
        unique case (bmap.kind)
          urfr_pkg::SRC_RAM:    e_ram  = 1'b1;
          urfr_pkg::SRC_ZERO:   e_byte = 8'h00;
          urfr_pkg::SRC_LEN:    e_byte = urfr_pkg::IP_TOTAL_LEN_LO;
          urfr_pkg::SRC_CKS_HI: e_byte = cur.cks[15:8];
          urfr_pkg::SRC_CKS_LO: e_byte = cur.cks[7:0];
          default:              e_byte = 8'h00;
        endcase
      end
      default: begin
        e_final = 1'b1;
      end
    endcase
  end

  assign ram_raddr = cur.bank ? urfr_pkg::RAM_AW'(e_src) + urfr_pkg::RAM_AW'(urfr_pkg::HDR_BYTES)
                              : urfr_pkg::RAM_AW'(e_src);

  // Take the next command when idle or on the final element
  assign load  = (!cur_valid || (issue && e_final)) && !q_empty;
  assign q_pop = load;

  // Free the bank once its last read has been issued
  assign rel.valid = issue && e_final && cur.kind != urfr_pkg::CMD_BYTE;
  assign rel.bank  = cur.bank;

  // Hold the current command and step through its elements
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (load) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (issue && e_final) begin
        cur_valid <= 1'b0;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Command and element payload
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
    s1_ram  <= e_ram;
    s1_byte <= e_byte;
    s1_last <= e_last;
  end

  // Output buffer
  assign ob_rd    = pop && !empty;
  assign empty    = ob_count == '0;
  assign out_byte = ob_byte[ob_rp];
  assign out_last = ob_last[ob_rp];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      ob_byte[ob_wp] <= s1_ram ? ram_rdata : s1_byte;
      ob_last[ob_wp] <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wp    <= '0;
      ob_rp    <= '0;
      ob_count <= '0;
    end else begin
      if (s1_valid) begin
        ob_wp <= ob_wp + 1'b1;
      end
      if (ob_rd) begin
        ob_rp <= ob_rp + 1'b1;
      end
      if (s1_valid && !ob_rd) begin
        ob_count <= ob_count + 1'b1;
      end else if (ob_rd && !s1_valid) begin
        ob_count <= ob_count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/udp_reply_frame_rewriter.sv =====
// ----------------------------------------------------------------------------
// udp_reply_frame_rewriter: UDP echo reply builder
// Usage:
//   Input queue: drive data_byte/last_byte with push; a byte is taken on a
//   clock edge with push high and full low. Bytes arrive in wire order,
//   last_byte marks the end of a frame.
//   Result queue: while empty is low, out_byte/out_last show the oldest
//   reply byte; pop with empty low takes it.
//   The first 38 bytes of a frame are held in a two-bank header store and
//   come out as one 38-byte burst once byte 37 is in (addresses and ports
//   swapped, total length 44, fresh header checksum). A shorter frame is
//   flushed unchanged at its last byte. Later bytes come out one for one.
//   A payload byte passes through the command queue, the current command
//   register and the s1 stage into the output buffer; a header burst takes
//   the same path once byte 37 is in. Throughput: one result byte per
//   cycle while the receiver pops. Intake is one byte per cycle until the
//   four-entry command queue fills behind a header burst; a header also
//   waits for its bank until the command two frames back has issued.
//   Reset: frame position, bank state and both queues clear; the header
//   store is not cleared. A stalled receiver fills the output buffer and
//   the command queue, after which full rises.
// ----------------------------------------------------------------------------
module udp_reply_frame_rewriter (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic                        q_full;
  logic                        q_empty;
  logic                        cmd_push;
  logic                        q_pop;
  urfr_pkg::cmd_t              cmd_in;
  urfr_pkg::cmd_t              cmd_head;
  urfr_pkg::release_t          rel;
  logic                        ram_we;
  logic [urfr_pkg::RAM_AW-1:0] ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [urfr_pkg::RAM_AW-1:0] ram_raddr;
  logic [7:0]                  ram_rdata;

  // Intake and classification
  urfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .full      (full),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .rel       (rel)
  );

  // Decoupling queue
  urfr_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_cmd (cmd_head),
    .empty  (q_empty)
  );

  // Two-bank header store
  urfr_ram #(
    .WIDTH (8),
    .DEPTH (urfr_pkg::RAM_DEPTH)
  ) u_hdr_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Execution and output buffer
  urfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (cmd_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
